FILE: rtl/utf16_to_utf8_transcoder_defines.svh
// assertion macros shared by the transcoder checker
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U2U8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define U2U8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/u2u8_pkg.sv
// shared types, constants and byte encoding for the utf-16 to utf-8 transcoder
`timescale 1ns / 1ps

package u2u8_pkg;

  localparam int CodeUnitW = 16;
  localparam int CpW       = 21;
  localparam int LeadBitsW = 10;
  localparam int LenW      = 2;

  localparam logic [CpW-1:0] SupplBase    = 21'h10000;
  localparam logic [CpW-1:0] Replacement  = 21'h0FFFD;
  localparam logic [CpW-1:0] MaxCodePoint = 21'h10FFFF;
  localparam logic [CpW-1:0] Max1Byte     = 21'h0007F;
  localparam logic [CpW-1:0] Max2Byte     = 21'h007FF;
  localparam logic [CpW-1:0] Max3Byte     = 21'h0FFFF;

  localparam logic [4:0] SurrogatePrefix = 5'b11011;

  localparam logic [7:0] Lead2Mark = 8'hC0;
  localparam logic [7:0] Lead3Mark = 8'hE0;
  localparam logic [7:0] Lead4Mark = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;

  // byte count minus one
  localparam logic [LenW-1:0] Len1 = 2'd0;
  localparam logic [LenW-1:0] Len2 = 2'd1;
  localparam logic [LenW-1:0] Len3 = 2'd2;
  localparam logic [LenW-1:0] Len4 = 2'd3;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            fin;
  } q_entry_t;

  // byte idx of the encoding of cp, len gives the byte count minus one
  function automatic logic [7:0] byte_of(logic [CpW-1:0] cp, logic [LenW-1:0] len,
                                         logic [LenW-1:0] idx);
    logic [LenW-1:0] rem;
    logic [7:0]      b;
    rem = len - idx;
    b   = 8'h00;
    if (len == Len1) begin
      b = {1'b0, cp[6:0]};
    end else if (idx == '0) begin
      case (len)
        Len2:    b = Lead2Mark | {3'b000, cp[10:6]};
        Len3:    b = Lead3Mark | {4'b0000, cp[15:12]};
        default: b = Lead4Mark | {5'b00000, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    b = ContMark | {2'b00, cp[5:0]};
        2'd1:    b = ContMark | {2'b00, cp[11:6]};
        default: b = ContMark | {2'b00, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

FILE: rtl/utf16_to_utf8_transcoder.sv
// top level of the utf-16 to utf-8 transcoder
`timescale 1ns / 1ps

// Takes one UTF-16 code unit per cycle while full is low and returns its UTF-8
// encoding as one to four byte beats, lead byte first, with run_end_o on the last
// byte of each unit's run and string_end_o on the last byte of the string. A
// surrogate unit is held and produces no beats; the next unit completes the pair.
// A surrogate that ends the string becomes U+FFFD. Units are taken back to back
// as long as the two-entry queue between the front and the serializer has room;
// the sustained rate is set by the serializer, which sends one byte per cycle while
// pop keeps the output free. With the serializer idle, the first byte of a unit
// passes through the queue, the working entry and the output byte register before
// it reaches the output ports.
module utf16_to_utf8_transcoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [u2u8_pkg::CodeUnitW-1:0] code_unit_i,
  input  logic                           final_unit_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     utf8_byte_o,
  output logic                           run_end_o,
  output logic                           string_end_o
);

  u2u8_pkg::q_entry_t fq_entry;
  u2u8_pkg::q_entry_t qb_entry;
  logic               fq_push;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  u2u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .q_full_i     (q_full),
    .q_push_o     (fq_push),
    .q_entry_o    (fq_entry)
  );

  u2u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .entry_i (fq_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (qb_entry)
  );

  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_entry_i    (qb_entry),
    .q_pop_o      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .utf8_byte_o  (utf8_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

endmodule

FILE: rtl/u2u8_front.sv
// front end: accepts code units, pairs surrogates and classifies code points
`timescale 1ns / 1ps

module u2u8_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [u2u8_pkg::CodeUnitW-1:0]    code_unit_i,
  input  logic                              final_unit_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output u2u8_pkg::q_entry_t                q_entry_o
);

  logic [u2u8_pkg::LeadBitsW-1:0] held_lead_bits_q, held_lead_bits_d;
  logic                           lead_pending_q, lead_pending_d;

  logic                       accept;
  logic                       is_sur;
  logic                       hold;
  logic [u2u8_pkg::CpW-1:0]   cp_pair;
  logic [u2u8_pkg::CpW-1:0]   cp_raw;
  logic [u2u8_pkg::CpW-1:0]   cp;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign is_sur = (code_unit_i[15:11] == u2u8_pkg::SurrogatePrefix);
  assign hold   = !lead_pending_q && is_sur && !final_unit_i;

  assign cp_pair = u2u8_pkg::SupplBase + {1'b0, held_lead_bits_q, code_unit_i[9:0]};

  always_comb begin
    if (lead_pending_q) begin
      cp_raw = cp_pair;
    end else if (is_sur) begin
      // lone surrogate at the end of the string
      cp_raw = u2u8_pkg::Replacement;
    end else begin
      cp_raw = {5'b00000, code_unit_i};
    end
    cp = (cp_raw > u2u8_pkg::MaxCodePoint) ? u2u8_pkg::Replacement : cp_raw;
  end

  always_comb begin
    q_entry_o.cp  = cp;
    q_entry_o.fin = final_unit_i;
    if (cp <= u2u8_pkg::Max1Byte) begin
      q_entry_o.len = u2u8_pkg::Len1;
    end else if (cp <= u2u8_pkg::Max2Byte) begin
      q_entry_o.len = u2u8_pkg::Len2;
    end else if (cp <= u2u8_pkg::Max3Byte) begin
      q_entry_o.len = u2u8_pkg::Len3;
    end else begin
      q_entry_o.len = u2u8_pkg::Len4;
    end
  end

  assign q_push_o = accept && !hold;

  always_comb begin
    held_lead_bits_d = held_lead_bits_q;
    lead_pending_d   = lead_pending_q;
    if (accept) begin
      if (lead_pending_q) begin
        held_lead_bits_d = '0;
        lead_pending_d   = 1'b0;
      end else if (hold) begin
        held_lead_bits_d = code_unit_i[9:0];
        lead_pending_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_bits_q <= '0;
      lead_pending_q   <= 1'b0;
    end else begin
      held_lead_bits_q <= held_lead_bits_d;
      lead_pending_q   <= lead_pending_d;
    end
  end

endmodule

FILE: rtl/u2u8_queue.sv
// short queue of classified code points between front and back
`timescale 1ns / 1ps

module u2u8_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u2u8_pkg::q_entry_t  entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output u2u8_pkg::q_entry_t  entry_o
);

  u2u8_pkg::q_entry_t mem_q [u2u8_pkg::QDepth];

  logic [u2u8_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [u2u8_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [u2u8_pkg::QCntW-1:0] cnt_q, cnt_d;

  logic do_push;
  logic do_pop;

  function automatic logic [u2u8_pkg::QPtrW-1:0] ptr_inc(logic [u2u8_pkg::QPtrW-1:0] p);
    logic [u2u8_pkg::QPtrW-1:0] r;
    if (p == u2u8_pkg::QPtrW'(u2u8_pkg::QDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == u2u8_pkg::QCntW'(u2u8_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/u2u8_back.sv
// back end: serializes each code point into utf-8 bytes, one beat per cycle while the output is free
`timescale 1ns / 1ps

module u2u8_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  u2u8_pkg::q_entry_t  q_entry_i,
  output logic                q_pop_o,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          utf8_byte_o,
  output logic                run_end_o,
  output logic                string_end_o
);

  u2u8_pkg::q_entry_t           cur_q, cur_d;
  logic                         cur_valid_q, cur_valid_d;
  logic [u2u8_pkg::LenW-1:0]    idx_q, idx_d;

  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   byte_q, byte_d;
  logic                         run_end_q, run_end_d;
  logic                         str_end_q, str_end_d;

  logic out_free;
  logic cur_last;
  logic advance;

  assign out_free = !out_valid_q || pop;
  assign cur_last = (idx_q == cur_q.len);
  assign advance  = cur_valid_q && out_free;
  // refill the working entry as its last byte leaves, so runs follow without a gap
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || (advance && cur_last));

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    run_end_d   = run_end_q;
    str_end_d   = str_end_q;
    if (advance) begin
      out_valid_d = 1'b1;
      byte_d      = u2u8_pkg::byte_of(cur_q.cp, cur_q.len, idx_q);
      run_end_d   = cur_last;
      str_end_d   = cur_last && cur_q.fin;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (advance) begin
      idx_d = idx_q + 1'b1;
    end
    if (q_pop_o) begin
      cur_d       = q_entry_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (advance && cur_last) begin
      cur_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    byte_q    <= byte_d;
    run_end_q <= run_end_d;
    str_end_q <= str_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty        = !out_valid_q;
  assign utf8_byte_o  = byte_q;
  assign run_end_o    = run_end_q;
  assign string_end_o = str_end_q;

endmodule

FILE: rtl/u2u8_checker.sv
// port-level checker for the transcoder, bound to the top level
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_defines.svh"

module u2u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  utf8_byte_o,
  input logic        run_end_o,
  input logic        string_end_o
);

  `U2U8_ASSERT_NOW(a_str_end_on_run_end, clk_i, rst_ni,
                   !empty && string_end_o, run_end_o,
                   "string end without run end")

  `U2U8_ASSERT_NOW(a_lead_not_last, clk_i, rst_ni,
                   !empty && (utf8_byte_o[7:6] == 2'b11), !run_end_o,
                   "multi-byte lead marked as run end")

  // a run continues in the very next cycle with a continuation byte
  `U2U8_ASSERT_NEXT(a_run_continues, clk_i, rst_ni,
                    !empty && pop && !run_end_o,
                    !empty && (utf8_byte_o[7:6] == 2'b10),
                    "run broken after non-final byte")

  `U2U8_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
                    !empty && !pop,
                    !empty && $stable(utf8_byte_o) && $stable(run_end_o),
                    "stalled beat changed")

endmodule

bind utf16_to_utf8_transcoder u2u8_checker u_u2u8_checker (.*);

FILE: sim/utf16_to_utf8_transcoder_tb.sv
// self-checking testbench for the utf-16 to utf-8 transcoder
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } utf8_beat_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        fin;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] bytes;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] code_unit_i = '0;
  logic        final_unit_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  utf8_byte_o;
  logic        run_end_o;
  logic        string_end_o;

  utf8_beat_t  beat_q[$];
  dir_row_t    dir_rows[$];
  logic [9:0]  held_bits = '0;
  logic        held_valid = 1'b0;
  int          err_cnt = 0;
  int          send_calm = 0;
  int          recv_calm = 0;

  utf16_to_utf8_transcoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .empty        (empty),
    .pop          (pop),
    .utf8_byte_o  (utf8_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // stretches of zero gaps now and then, otherwise a uniformly drawn idle gap
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
  endtask

  // updates the surrogate hold state and returns the byte count, lead byte in enc[0]
  function automatic int encode_unit(input logic [15:0] u, input logic f,
                                     output logic [3:0][7:0] enc);
    logic [u2u8_pkg::CpW-1:0] cp;
    enc = '0;
    if (held_valid) begin
      cp = u2u8_pkg::SupplBase + {1'b0, held_bits, u[9:0]};
      held_valid = 1'b0;
      held_bits = '0;
    end else if (u[15:11] == u2u8_pkg::SurrogatePrefix) begin
      if (!f) begin
        held_bits = u[9:0];
        held_valid = 1'b1;
        return 0;
      end
      cp = u2u8_pkg::Replacement;
    end else begin
      cp = {5'b0, u};
    end
    if (cp > u2u8_pkg::MaxCodePoint) cp = u2u8_pkg::Replacement;
    if (cp <= u2u8_pkg::Max1Byte) begin
      enc[0] = cp[7:0];
      return 1;
    end else if (cp <= u2u8_pkg::Max2Byte) begin
      enc[0] = u2u8_pkg::Lead2Mark | {3'b000, cp[10:6]};
      enc[1] = u2u8_pkg::ContMark | {2'b00, cp[5:0]};
      return 2;
    end else if (cp <= u2u8_pkg::Max3Byte) begin
      enc[0] = u2u8_pkg::Lead3Mark | {4'b0000, cp[15:12]};
      enc[1] = u2u8_pkg::ContMark | {2'b00, cp[11:6]};
      enc[2] = u2u8_pkg::ContMark | {2'b00, cp[5:0]};
      return 3;
    end
    enc[0] = u2u8_pkg::Lead4Mark | {5'b00000, cp[20:18]};
    enc[1] = u2u8_pkg::ContMark | {2'b00, cp[17:12]};
    enc[2] = u2u8_pkg::ContMark | {2'b00, cp[11:6]};
    enc[3] = u2u8_pkg::ContMark | {2'b00, cp[5:0]};
    return 4;
  endfunction

  task automatic queue_beats(input logic [3:0][7:0] enc, input int n, input logic f);
    utf8_beat_t b;
    for (int i = 0; i < n; i++) begin
      b.data = enc[i];
      b.run_end = (i == n - 1);
      b.str_end = f && (i == n - 1);
      beat_q.push_back(b);
    end
  endtask

  // push stays high across back-to-back units, lowered here only for a gap
  task automatic send_unit(input logic [15:0] u, input logic f);
    int gap;
    draw_gap(send_calm, gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    code_unit_i <= u;
    final_unit_i <= f;
    do @(posedge clk_i); while (full !== 1'b0);
  endtask

  task automatic send_predicted(input logic [15:0] u, input logic f);
    logic [3:0][7:0] enc;
    int n;
    send_unit(u, f);
    n = encode_unit(u, f, enc);
    queue_beats(enc, n, f);
  endtask

  task automatic drain_all();
    push <= 1'b0;
    @(posedge clk_i);
    while (beat_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [15:0] u, input logic f, input logic typed,
                         input int n, input logic [31:0] bytes);
    dir_row_t r;
    r.unit = u;
    r.fin = f;
    r.typed = typed;
    r.n = n[2:0];
    r.bytes = bytes;
    dir_rows.push_back(r);
  endtask

  // result side: random stalls on pop, each accepted beat checked against the oldest
  initial begin
    int gap;
    utf8_beat_t want;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      draw_gap(recv_calm, gap);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      if (beat_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %02h", utf8_byte_o));
      end else begin
        want = beat_q.pop_front();
        if (utf8_byte_o !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", utf8_byte_o, want.data));
        if (run_end_o !== want.run_end)
          report_mismatch($sformatf("run_end %b, want %b", run_end_o, want.run_end));
        if (string_end_o !== want.str_end)
          report_mismatch($sformatf("string_end %b, want %b", string_end_o, want.str_end));
      end
    end
  end

  initial begin
    logic [3:0][7:0] enc;
    logic [15:0] u;
    logic        f;
    int n;
    int items;
    int kind;

    // unit, final, typed, byte count, bytes with the lead byte highest
    add_row(16'h0000, 1'b0, 1'b1, 1, 32'h0000_0000);
    add_row(16'h007F, 1'b0, 1'b1, 1, 32'h0000_007F);
    add_row(16'h0080, 1'b0, 1'b1, 2, 32'h0000_C280);
    add_row(16'h07FF, 1'b0, 1'b1, 2, 32'h0000_DFBF);
    add_row(16'h0800, 1'b0, 1'b1, 3, 32'h00E0_A080);
    add_row(16'hFFFF, 1'b0, 1'b1, 3, 32'h00EF_BFBF);
    add_row(16'hD800, 1'b0, 1'b1, 0, 32'h0);
    add_row(16'hDC00, 1'b0, 1'b1, 4, 32'hF090_8080);
    add_row(16'hDBFF, 1'b0, 1'b1, 0, 32'h0);
    add_row(16'hDFFF, 1'b1, 1'b1, 4, 32'hF48F_BFBF);
    // lone surrogate closing the string
    add_row(16'hD800, 1'b1, 1'b1, 3, 32'h00EF_BFBD);
    add_row(16'hDFFF, 1'b1, 1'b1, 3, 32'h00EF_BFBD);
    // low surrogate taken as lead, then a plain unit as trail
    add_row(16'hDC05, 1'b0, 1'b1, 0, 32'h0);
    add_row(16'h0041, 1'b0, 1'b0, 0, 32'h0);
    // second lead consumed as trail
    add_row(16'hD812, 1'b0, 1'b1, 0, 32'h0);
    add_row(16'hD834, 1'b0, 1'b0, 0, 32'h0);
    add_row(16'hABCD, 1'b1, 1'b0, 0, 32'h0);
    add_row(16'h0041, 1'b1, 1'b1, 1, 32'h0000_0041);
    add_row(16'hFFFF, 1'b1, 1'b1, 3, 32'h00EF_BFBF);
    add_row(16'h5555, 1'b0, 1'b0, 0, 32'h0);
    add_row(16'hAAAA, 1'b0, 1'b0, 0, 32'h0);
    // trail that also ends the string
    add_row(16'hD800, 1'b0, 1'b1, 0, 32'h0);
    add_row(16'hFFFF, 1'b1, 1'b0, 0, 32'h0);
    add_row(16'h07FF, 1'b1, 1'b1, 2, 32'h0000_DFBF);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_unit(dir_rows[i].unit, dir_rows[i].fin);
      n = encode_unit(dir_rows[i].unit, dir_rows[i].fin, enc);
      if (dir_rows[i].typed) begin
        n = int'(dir_rows[i].n);
        enc = '0;
        for (int k = 0; k < n; k++) enc[k] = dir_rows[i].bytes[8*(n-1-k) +: 8];
      end
      queue_beats(enc, n, dir_rows[i].fin);
    end

    // hold the sender until the output side has caught up
    drain_all();

    items = 0;
    while (items < 96) begin
      kind = $urandom_range(0, 9);
      f = ($urandom_range(0, 5) == 0);
      case (kind)
        0, 1, 2: begin
          u = 16'($urandom_range(16'h0000, 16'h007F));
          send_predicted(u, f);
          items++;
        end
        3, 4: begin
          u = 16'($urandom_range(16'h0080, 16'h07FF));
          send_predicted(u, f);
          items++;
        end
        5: begin
          u = 16'($urandom_range(16'h0800, 16'hD7FF));
          send_predicted(u, f);
          items++;
        end
        6: begin
          u = 16'($urandom_range(16'hE000, 16'hFFFF));
          send_predicted(u, f);
          items++;
        end
        7, 8: begin
          // well-formed pair
          send_predicted(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
          send_predicted(16'($urandom_range(16'hDC00, 16'hDFFF)), f);
          items += 2;
        end
        default: begin
          // noise: any unit, lone surrogates and broken pairs included
          send_predicted(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
          items++;
          if ($urandom_range(0, 1) == 0) begin
            send_predicted(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
            items++;
          end
        end
      endcase
      if (f && $urandom_range(0, 7) == 0) drain_all();
    end

    drain_all();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/u2u8_pkg.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_transcoder.sv
rtl/u2u8_checker.sv
sim/utf16_to_utf8_transcoder_tb.sv
